FILE: src/brace_list_syntax_checker_macros.svh
// Assertion macros for the brace-list checker.
`ifndef BRACE_LIST_SYNTAX_CHECKER_MACROS_SVH
`define BRACE_LIST_SYNTAX_CHECKER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BLS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bls assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define BLS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bls assertion failed");

`endif

FILE: src/bls_pkg.sv
package bls_pkg;

  localparam int DEPTH_WIDTH_DEF  = 16;
  localparam int SYMBOL_WIDTH_DEF = 16;

  localparam int ERR_W = 6;
  localparam int CLS_W = 4;

  // error flag bits
  localparam int ERR_EXTRA_CLOSE = 0;
  localparam int ERR_BAD_SEP     = 1;
  localparam int ERR_UNKNOWN     = 2;
  localparam int ERR_UNFINISHED  = 3;
  localparam int ERR_OPEN        = 4;
  localparam int ERR_DEPTH       = 5;

  localparam logic [CLS_W-1:0] CLS_NONE     = 4'd0;
  localparam logic [CLS_W-1:0] CLS_NUMBER   = 4'd1;
  localparam logic [CLS_W-1:0] CLS_NUM_EXP  = 4'd2;
  localparam logic [CLS_W-1:0] CLS_GUID     = 4'd3;
  localparam logic [CLS_W-1:0] CLS_BASE64   = 4'd4;
  localparam logic [CLS_W-1:0] CLS_LINK     = 4'd5;
  localparam logic [CLS_W-1:0] CLS_PLAIN64  = 4'd6;
  localparam logic [CLS_W-1:0] CLS_DATA     = 4'd7;
  localparam logic [CLS_W-1:0] CLS_UNKNOWN  = 4'd8;

  // per-symbol character classes
  typedef struct packed {
    logic ws;
    logic dig;
    logic hex;
    logic b64;
    logic comma;
    logic quote;
    logic lbrace;
    logic rbrace;
    logic minus;
    logic dot;
    logic exp;
    logic colon;
    logic ascii;
    logic [7:0] ch;
  } cc_t;

  // recognizer control from the parser
  typedef struct packed {
    logic clear;
    logic feed;
    logic restart;
  } rec_ctl_t;

  typedef struct packed {
    logic [ERR_W-1:0] flags;
    logic [CLS_W-1:0] cls;
    logic             ok;
    logic             done;
  } res_t;

  function automatic cc_t char_class(input logic ascii, input logic [7:0] ch);
    cc_t c;
    logic d, lo, up;
    d  = ascii && ch >= 8'h30 && ch <= 8'h39;
    lo = ascii && ch >= 8'h61 && ch <= 8'h7A;
    up = ascii && ch >= 8'h41 && ch <= 8'h5A;
    c.ascii  = ascii;
    c.ch     = ch;
    c.dig    = d;
    c.hex    = d || (ascii && ((ch >= 8'h61 && ch <= 8'h66) ||
                               (ch >= 8'h41 && ch <= 8'h46)));
    c.ws     = ascii && (ch == 8'h20 || ch == 8'h09 || ch == 8'h0D || ch == 8'h0A);
    c.b64    = d || lo || up ||
               (ascii && (ch == 8'h2B || ch == 8'h3D || ch == 8'h2F ||
                          ch == 8'h0D || ch == 8'h0A));
    c.comma  = ascii && ch == 8'h2C;
    c.quote  = ascii && ch == 8'h22;
    c.lbrace = ascii && ch == 8'h7B;
    c.rbrace = ascii && ch == 8'h7D;
    c.minus  = ascii && ch == 8'h2D;
    c.dot    = ascii && ch == 8'h2E;
    c.exp    = ascii && (ch == 8'h65 || ch == 8'h45);
    c.colon  = ascii && ch == 8'h3A;
    return c;
  endfunction

endpackage

FILE: src/bls_recog.sv
module bls_recog import bls_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  rec_ctl_t         ctl,
  input  cc_t              c,
  output logic [CLS_W-1:0] value_class
);

  localparam logic [3:0] N_START = 4'd0;
  localparam logic [3:0] N_SIGN  = 4'd1;
  localparam logic [3:0] N_INT   = 4'd2;
  localparam logic [3:0] N_DOT   = 4'd3;
  localparam logic [3:0] N_FRAC  = 4'd4;
  localparam logic [3:0] N_E     = 4'd5;
  localparam logic [3:0] N_ESIGN = 4'd6;
  localparam logic [3:0] N_EXP   = 4'd7;
  localparam logic [3:0] N_DEAD  = 4'd8;

  localparam logic [5:0] G_DONE = 6'd36;
  localparam logic [5:0] G_DEAD = 6'd63;

  localparam logic [6:0] L_START  = 7'd0;
  localparam logic [6:0] L_DIGITS = 7'd1;
  localparam logic [6:0] L_HEX0   = 7'd2;
  localparam logic [6:0] L_DONE   = 7'd34;
  localparam logic [6:0] L_DEAD   = 7'd127;

  localparam logic [3:0] B64_LEN  = 4'd8;
  localparam logic [3:0] B64_DEAD = 4'd15;
  localparam logic [2:0] DAT_LEN  = 3'd6;
  localparam logic [2:0] DAT_DEAD = 3'd7;

  function automatic logic [7:0] b64_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = 8'h23;
      3'd1:    r = 8'h62;
      3'd2:    r = 8'h61;
      3'd3:    r = 8'h73;
      3'd4:    r = 8'h65;
      3'd5:    r = 8'h36;
      3'd6:    r = 8'h34;
      default: r = 8'h3A;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] dat_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = 8'h23;
      3'd1:    r = 8'h64;
      3'd2:    r = 8'h61;
      3'd3:    r = 8'h74;
      3'd4:    r = 8'h61;
      default: r = 8'h3A;
    endcase
    return r;
  endfunction

  logic [3:0] num, num_base, num_next;
  logic [5:0] guid, guid_base, guid_next;
  logic [6:0] link, link_base, link_next;
  logic       flag, flag_base, flag_next;
  logic [3:0] bp, bp_base, bp_next;
  logic [2:0] dp, dp_base, dp_next;
  logic       dash;

  always_comb begin
    num_base  = ctl.restart ? N_START : num;
    guid_base = ctl.restart ? 6'd0 : guid;
    link_base = ctl.restart ? L_START : link;
    flag_base = ctl.restart ? 1'b1 : flag;
    bp_base   = ctl.restart ? 4'd0 : bp;
    dp_base   = ctl.restart ? 3'd0 : dp;

    case (num_base)
      N_START: num_next = c.minus ? N_SIGN : (c.dig ? N_INT : N_DEAD);
      N_SIGN:  num_next = c.dig ? N_INT : N_DEAD;
      N_INT:   num_next = c.dig ? N_INT : (c.dot ? N_DOT : (c.exp ? N_E : N_DEAD));
      N_DOT, N_FRAC: num_next = c.dig ? N_FRAC : (c.exp ? N_E : N_DEAD);
      N_E:     num_next = c.minus ? N_ESIGN : (c.dig ? N_EXP : N_DEAD);
      N_ESIGN, N_EXP: num_next = c.dig ? N_EXP : N_DEAD;
      default: num_next = N_DEAD;
    endcase

    dash = guid_base == 6'd8 || guid_base == 6'd13 ||
           guid_base == 6'd18 || guid_base == 6'd23;
    if (guid_base >= G_DONE) guid_next = G_DEAD;
    else if (dash) guid_next = c.minus ? guid_base + 6'd1 : G_DEAD;
    else guid_next = c.hex ? guid_base + 6'd1 : G_DEAD;

    if (link_base == L_START) link_next = c.dig ? L_DIGITS : L_DEAD;
    else if (link_base == L_DIGITS) link_next = c.dig ? L_DIGITS : (c.colon ? L_HEX0 : L_DEAD);
    else if (link_base >= L_HEX0 && link_base < L_DONE)
      link_next = c.hex ? link_base + 7'd1 : L_DEAD;
    else link_next = L_DEAD;

    flag_next = flag_base && c.b64;
    if (bp_base < B64_LEN)
      bp_next = (c.ascii && c.ch == b64_char(bp_base[2:0])) ? bp_base + 4'd1 : B64_DEAD;
    else if (bp_base == B64_LEN) bp_next = c.b64 ? B64_LEN : B64_DEAD;
    else bp_next = bp_base;
    if (dp_base < DAT_LEN)
      dp_next = (c.ascii && c.ch == dat_char(dp_base)) ? dp_base + 3'd1 : DAT_DEAD;
    else if (dp_base == DAT_LEN) dp_next = c.b64 ? DAT_LEN : DAT_DEAD;
    else dp_next = dp_base;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && ctl.clear)) begin
      num  <= N_START;
      guid <= 6'd0;
      link <= L_START;
      flag <= 1'b1;
      bp   <= 4'd0;
      dp   <= 3'd0;
    end else if (step && ctl.feed) begin
      num  <= num_next;
      guid <= guid_next;
      link <= link_next;
      flag <= flag_next;
      bp   <= bp_next;
      dp   <= dp_next;
    end
  end

  always_comb begin
    if (num == N_INT) value_class = CLS_NUMBER;
    else if (num == N_DOT || num == N_FRAC || num == N_EXP) value_class = CLS_NUM_EXP;
    else if (guid == G_DONE) value_class = CLS_GUID;
    else if (bp == B64_LEN) value_class = CLS_BASE64;
    else if (link == L_DONE) value_class = CLS_LINK;
    else if (flag) value_class = CLS_PLAIN64;
    else if (dp == DAT_LEN) value_class = CLS_DATA;
    else value_class = CLS_UNKNOWN;
  end

endmodule

FILE: src/bls_core.sv
module bls_core import bls_pkg::*; #(
  parameter int DEPTH_WIDTH = DEPTH_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic                   eot,
  input  cc_t                    c,
  input  logic [CLS_W-1:0]       rec_class,
  output rec_ctl_t               ctl,
  output res_t                   res,
  output logic [DEPTH_WIDTH-1:0] depth
);

  typedef enum logic [4:0] {
    M_VALUE  = 5'b00001,
    M_DELIM  = 5'b00010,
    M_STRING = 5'b00100,
    M_QUOTE  = 5'b01000,
    M_BARE   = 5'b10000
  } mode_t;

  localparam logic [DEPTH_WIDTH-1:0] LVL_MAX = {1'b0, {(DEPTH_WIDTH-1){1'b1}}};
  localparam logic [DEPTH_WIDTH-1:0] LVL_MIN = {1'b1, {(DEPTH_WIDTH-1){1'b0}}};
  localparam logic [DEPTH_WIDTH-1:0] LVL_ONE = {{(DEPTH_WIDTH-1){1'b0}}, 1'b1};

  mode_t                   mode, mode_next;
  logic [DEPTH_WIDTH-1:0]  level, level_next, level_dec, level_inc;
  logic                    ok, ok_next, stopped, stopped_next;
  logic [ERR_W-1:0]        flags, cb_flags;
  logic                    lvl_pos;

  always_comb begin
    lvl_pos   = !level[DEPTH_WIDTH-1] && (level != '0);
    level_dec = (level == LVL_MIN) ? level : level - LVL_ONE;
    level_inc = (level == LVL_MAX) ? level : level + LVL_ONE;
    cb_flags  = '0;
    cb_flags[ERR_EXTRA_CLOSE] = !lvl_pos;
    cb_flags[ERR_DEPTH]       = (level == LVL_MIN);
  end

  always_comb begin
    flags        = '0;
    res.cls      = CLS_NONE;
    mode_next    = mode;
    level_next   = level;
    stopped_next = stopped;
    ctl          = '0;
    depth        = level;
    if (eot) begin
      ctl.clear = 1'b1;
      if (!stopped) begin
        if (mode == M_BARE) begin
          res.cls = rec_class;
          flags[ERR_UNKNOWN] = (rec_class == CLS_UNKNOWN);
        end else if (mode != M_QUOTE && mode != M_DELIM) begin
          flags[ERR_UNFINISHED] = 1'b1;
        end
        flags[ERR_OPEN] = lvl_pos;
      end
      ok_next      = 1'b1;
      res.ok       = ok && (flags == '0);
      res.done     = 1'b1;
      mode_next    = M_VALUE;
      level_next   = '0;
      stopped_next = 1'b0;
    end else if (stopped) begin
      ok_next  = ok;
      res.ok   = ok;
      res.done = 1'b1;
    end else begin
      unique case (mode)
        M_VALUE: begin
          if (c.ws || c.comma) begin
            mode_next = M_VALUE;
          end else if (c.quote) begin
            mode_next = M_STRING;
          end else if (c.lbrace) begin
            flags[ERR_DEPTH] = (level == LVL_MAX);
            level_next = level_inc;
          end else if (c.rbrace) begin
            flags      = cb_flags;
            level_next = level_dec;
            mode_next  = M_DELIM;
          end else begin
            ctl.feed    = 1'b1;
            ctl.restart = 1'b1;
            mode_next   = M_BARE;
          end
        end
        M_STRING: begin
          if (c.quote) mode_next = M_QUOTE;
        end
        M_QUOTE: begin
          if (c.quote) begin
            mode_next = M_STRING;
          end else if (c.ws) begin
            mode_next = M_DELIM;
          end else if (c.comma) begin
            mode_next = M_VALUE;
          end else if (c.rbrace) begin
            flags      = cb_flags;
            level_next = level_dec;
            mode_next  = M_DELIM;
          end else begin
            flags[ERR_BAD_SEP] = 1'b1;
          end
        end
        M_BARE: begin
          if (c.comma || c.rbrace) begin
            res.cls = rec_class;
            if (c.rbrace) begin
              flags      = cb_flags;
              level_next = level_dec;
              mode_next  = M_DELIM;
            end else begin
              mode_next = M_VALUE;
            end
            flags[ERR_UNKNOWN] = (rec_class == CLS_UNKNOWN);
          end else begin
            ctl.feed = 1'b1;
          end
        end
        M_DELIM: begin
          if (c.comma) begin
            mode_next = M_VALUE;
          end else if (c.rbrace) begin
            flags      = cb_flags;
            level_next = level_dec;
          end else if (!c.ws) begin
            flags[ERR_BAD_SEP] = 1'b1;
          end
        end
        default: mode_next = M_VALUE;
      endcase
      ok_next      = ok && (flags == '0);
      stopped_next = flags[ERR_BAD_SEP];
      res.ok       = ok_next;
      res.done     = stopped_next;
      depth        = level_next;
    end
    res.flags = flags;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= M_VALUE;
      level   <= '0;
      ok      <= 1'b1;
      stopped <= 1'b0;
    end else if (step) begin
      mode    <= mode_next;
      level   <= level_next;
      ok      <= ok_next;
      stopped <= stopped_next;
    end
  end

endmodule

FILE: src/brace_list_syntax_checker.sv
// Brace-list syntax checker.
// Input stream: one beat per UTF-16 code unit of the text. s_tdata carries the
// symbol; s_tlast = 1 marks an end beat that carries no character, runs the
// end-of-text checks and returns the checker to its start state.
// Output stream: exactly one beat per input beat, in order. m_tdata carries
// error flags, value class and nesting depth; m_tuser is text_ok and m_tlast
// is text_done (end beat, or a fatal separator error and after).
// The input register takes the beat; the result register loads its result
// when the output is free (m_tvalid low or m_tready high).
// Throughput: one beat per cycle while the output is not stalled; the parse
// state and value recognizers update once per beat.
// Stall: when m_tready is low the result register holds and the input
// register takes one more beat, then s_tready drops until the output drains.
// Reset (rst, synchronous): empties both registers, sets value mode, depth 0,
// text_ok 1 and clears the recognizers. No clearing pass is needed.
module brace_list_syntax_checker import bls_pkg::*; #(
  parameter int DEPTH_WIDTH  = DEPTH_WIDTH_DEF,
  parameter int SYMBOL_WIDTH = SYMBOL_WIDTH_DEF,
  localparam int IN_W  = ((SYMBOL_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((ERR_W + CLS_W + DEPTH_WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // symbol
  input  logic             s_tlast,   // end_of_text
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // error_flags, value_class, nest_depth
  output logic             m_tuser,   // text_ok
  output logic             m_tlast    // text_done
);

  logic                    in_valid, in_eot, out_free, step;
  logic [SYMBOL_WIDTH-1:0] in_sym;
  cc_t                     cc;
  rec_ctl_t                ctl;
  res_t                    res, out_res;
  logic [CLS_W-1:0]        rec_class;
  logic [DEPTH_WIDTH-1:0]  depth, out_depth;

  assign out_free = !m_tvalid || m_tready;
  assign step     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sym <= s_tdata[SYMBOL_WIDTH-1:0];
      in_eot <= s_tlast;
    end
  end

  assign cc = char_class((in_sym >> 8) == '0, in_sym[7:0]);

  bls_recog u_recog (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .ctl         (ctl),
    .c           (cc),
    .value_class (rec_class)
  );

  bls_core #(
    .DEPTH_WIDTH (DEPTH_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .eot       (in_eot),
    .c         (cc),
    .rec_class (rec_class),
    .ctl       (ctl),
    .res       (res),
    .depth     (depth)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res   <= res;
      out_depth <= depth;
    end
  end

  assign m_tdata = OUT_W'({out_depth, out_res.cls, out_res.flags});
  assign m_tuser = out_res.ok;
  assign m_tlast = out_res.done;

endmodule

FILE: src/bls_checker.sv
`include "brace_list_syntax_checker_macros.svh"

module bls_checker import bls_pkg::*; #(
  parameter int DEPTH_WIDTH = DEPTH_WIDTH_DEF,
  localparam int OUT_W = ((ERR_W + CLS_W + DEPTH_WIDTH + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tuser,
  input logic             m_tlast
);

  logic [ERR_W-1:0] flags;
  logic [CLS_W-1:0] cls;

  assign flags = m_tdata[ERR_W-1:0];
  assign cls   = m_tdata[ERR_W+CLS_W-1:ERR_W];

  `BLS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `BLS_ASSERT_NOW(a_err_clears_ok, m_tvalid && (flags != '0), !m_tuser)
  `BLS_ASSERT_NOW(a_bad_sep_done, m_tvalid && flags[ERR_BAD_SEP], m_tlast)
  `BLS_ASSERT_NOW(a_unknown_flag, m_tvalid, (cls == CLS_UNKNOWN) == flags[ERR_UNKNOWN])

endmodule

bind brace_list_syntax_checker bls_checker #(.DEPTH_WIDTH(DEPTH_WIDTH)) u_bls_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
